FILE: design/assert_macros.svh
// assertion macros used by the wheel power limiter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WPL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wheel power limiter assertion failed");
`define WPL_ASSERT_NEXT(label, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error("wheel power limiter assertion failed");
`else
`define WPL_ASSERT(label, prop)
`define WPL_ASSERT_NEXT(label, cond, expect_next)
`endif
`endif

FILE: design/wpl_pkg.sv
// shared constants, types and helpers for the wheel power limiter
`default_nettype none
package wpl_pkg;
  localparam int WHEELS    = 4;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 64 - FRAC_BITS;
  localparam int SUM_W     = VAL_W + 4;
  localparam int TQ_W      = 24;
  localparam int SPD_W     = 16;
  localparam int K_W       = 24;
  localparam int LIM_W     = 10;
  localparam int BOOST_W   = 26;
  localparam int ENERGY_W  = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int MUL_CHUNK = 8;
  localparam int MUL_STEPS = (VAL_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MB_W      = MUL_STEPS * MUL_CHUNK;
  localparam int DIV_N     = 64;
  localparam int DIV_D     = VAL_W;
  localparam int SQ_IN     = 64;
  localparam int SQ_OUT    = 32;
  localparam int LANE_IW   = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int TOT_W     = VAL_W + LANE_IW + 1;

  localparam logic [LIM_W-1:0]    LIM_THRESH = LIM_W'(90);
  localparam int                  LIM_MARGIN = 5;
  localparam logic [ENERGY_W-1:0] ENERGY_SET = ENERGY_W'(6);
  localparam logic [ENERGY_W-1:0] ENERGY_CLR = ENERGY_W'(10);

  localparam logic [K_W-1:0]     K1_RESET    = K_W'(65536);
  localparam logic [K_W-1:0]     GAIN_RESET  = K_W'(65536);
  localparam logic [LIM_W-1:0]   LIMIT_RESET = LIM_W'(60);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] wide_t;

  localparam wide_t QMAX_WIDE = wide_t'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
  localparam val_t  QMAX      = val_t'(QMAX_WIDE);

  localparam logic [DIV_N-1:0] TQ_POS_LIM = DIV_N'((64'd1 << (TQ_W - 1)) - 64'd1);
  localparam logic [DIV_N-1:0] TQ_NEG_LIM = DIV_N'(64'd1 << (TQ_W - 1));
  localparam logic signed [TQ_W-1:0] TQ_MAX_S = TQ_W'((64'd1 << (TQ_W - 1)) - 64'd1);
  localparam logic signed [TQ_W-1:0] TQ_MIN_S = TQ_W'(64'd1 << (TQ_W - 1));

  typedef enum logic [2:0] {
    REG_K1     = 3'd0,
    REG_K2     = 3'd1,
    REG_CST    = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_BOOST  = 3'd4,
    REG_CAP_EN = 3'd5,
    REG_GAIN   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_TW, OP_K1T, OP_K1TT, OP_K2W, OP_K2WW, OP_PS, OP_BB, OP_K1C
  } op_t;

  typedef enum logic [3:0] {
    L_IDLE, L_W, L_GO, L_MW, L_CST, L_WAIT, L_C1, L_C2, L_D, L_SQ, L_NUM, L_DIV
  } lane_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_P1, T_SUM, T_CMP, T_DIV, T_GO2, T_P2, T_OUT
  } top_state_t;

  typedef struct packed {
    logic [K_W-1:0] k1;
    logic [K_W-1:0] k2;
    logic [K_W-1:0] cst;
    logic [K_W-1:0] gain;
  } lane_cfg_t;

  typedef struct packed {
    logic start1;
    logic start2;
    logic rescale;
    val_t scale;
  } lane_ctl_t;

  typedef struct packed {
    logic p1_done;
    logic p2_done;
  } lane_stat_t;

  function automatic val_t clampq(wide_t v);
    if (v > QMAX_WIDE) return QMAX;
    if (v < -QMAX_WIDE) return -QMAX;
    return val_t'(v);
  endfunction
endpackage
`default_nettype wire

FILE: design/wheel_power_limiter.sv
// wheel power limiter top level: config registers, lanes and merge stage
// processing takes longer when the torques are rescaled; it is set by the 64-bit budget
//   and torque dividers, the 32-bit square root and the byte-serial lane multipliers
// one item at a time; a new item is taken only after the previous result has been loaded
//   into the output register, which waits while out_valid is held and out_ready is low
// reset: synchronous; registers return to defaults and the capacitor counts as lacking
`default_nettype none
`include "assert_macros.svh"
module wheel_power_limiter import wpl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TQ_W-1:0]   torque_0,
  input  logic signed [TQ_W-1:0]   torque_1,
  input  logic signed [TQ_W-1:0]   torque_2,
  input  logic signed [TQ_W-1:0]   torque_3,
  input  logic signed [SPD_W-1:0]  speed_0,
  input  logic signed [SPD_W-1:0]  speed_1,
  input  logic signed [SPD_W-1:0]  speed_2,
  input  logic signed [SPD_W-1:0]  speed_3,
  input  logic [ENERGY_W-1:0]      cap_energy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TQ_W-1:0]   limited_torque_0,
  output logic signed [TQ_W-1:0]   limited_torque_1,
  output logic signed [TQ_W-1:0]   limited_torque_2,
  output logic signed [TQ_W-1:0]   limited_torque_3,
  output logic                     was_limited,
  output logic                     cap_short
);
  top_state_t state, state_next;

  logic [K_W-1:0]     k1, k2, cst, gain;
  logic [LIM_W-1:0]   limit;
  logic [BOOST_W-1:0] boost;
  logic               cap_en;
  logic               cap_lacking, lack_next;

  logic signed [TQ_W-1:0]  tq_in [WHEELS];
  logic signed [SPD_W-1:0] sp_in [WHEELS];
  logic signed [TQ_W-1:0]  tq_r  [WHEELS];
  logic signed [SPD_W-1:0] sp_r  [WHEELS];
  logic signed [TQ_W-1:0]  res   [WHEELS];
  logic signed [TQ_W-1:0]  out_tq [WHEELS];
  val_t                    power [WHEELS];
  lane_stat_t              stat  [WHEELS];
  logic [WHEELS-1:0]       p1_done_vec, p2_done_vec;

  lane_cfg_t  cfg;
  lane_ctl_t  ctl;
  logic       accept, wr_en, out_load, div_start, div_done, limited;
  logic       rescale, limited_now;
  val_t       budget, budget_next, scale;
  logic [TOT_W-1:0]   total_acc;
  logic [VAL_W-1:0]   total_sat;
  logic [LANE_IW-1:0] idx;
  logic [DIV_N-1:0]   div_quo;
  logic [VAL_W-1:0]   bud_mag;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign accept = in_valid && in_ready;
  assign in_ready = (state == T_IDLE);

  assign tq_in[0] = torque_0;
  assign tq_in[1] = torque_1;
  assign tq_in[2] = torque_2;
  assign tq_in[3] = torque_3;
  assign sp_in[0] = speed_0;
  assign sp_in[1] = speed_1;
  assign sp_in[2] = speed_2;
  assign sp_in[3] = speed_3;
  assign limited_torque_0 = out_tq[0];
  assign limited_torque_1 = out_tq[1];
  assign limited_torque_2 = out_tq[2];
  assign limited_torque_3 = out_tq[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      k1     <= K1_RESET;
      k2     <= '0;
      cst    <= '0;
      limit  <= LIMIT_RESET;
      boost  <= '0;
      cap_en <= 1'b0;
      gain   <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_K1:     k1     <= pwdata[K_W-1:0];
        REG_K2:     k2     <= pwdata[K_W-1:0];
        REG_CST:    cst    <= pwdata[K_W-1:0];
        REG_LIMIT:  limit  <= pwdata[LIM_W-1:0];
        REG_BOOST:  boost  <= pwdata[BOOST_W-1:0];
        REG_CAP_EN: cap_en <= pwdata[0];
        REG_GAIN:   gain   <= pwdata[K_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_K1:     prdata = DATA_W'(k1);
      REG_K2:     prdata = DATA_W'(k2);
      REG_CST:    prdata = DATA_W'(cst);
      REG_LIMIT:  prdata = DATA_W'(limit);
      REG_BOOST:  prdata = DATA_W'(boost);
      REG_CAP_EN: prdata = DATA_W'(cap_en);
      REG_GAIN:   prdata = DATA_W'(gain);
      default:    prdata = '0;
    endcase
  end

  // hysteresis on the capacitor energy reading
  always_comb begin
    if (cap_energy <= ENERGY_SET) lack_next = 1'b1;
    else if (cap_energy > ENERGY_CLR) lack_next = 1'b0;
    else lack_next = cap_lacking;
  end

  always_comb begin
    budget_next = val_t'({limit, {FRAC_BITS{1'b0}}});
    if (limit <= LIM_THRESH) budget_next = budget_next - val_t'(LIM_MARGIN <<< FRAC_BITS);
    if (cap_en && !lack_next) budget_next = budget_next + val_t'(boost);
  end

  assign total_sat   = (total_acc > TOT_W'(QMAX)) ? VAL_W'(QMAX) : total_acc[VAL_W-1:0];
  assign limited_now = $signed({1'b0, total_sat}) > $signed({budget[VAL_W-1], budget});
  assign bud_mag     = budget[VAL_W-1] ? VAL_W'(-budget) : VAL_W'(budget);
  assign div_start   = (state == T_CMP) && limited_now && total_sat != '0 && k1 != '0;

  assign cfg.k1   = k1;
  assign cfg.k2   = k2;
  assign cfg.cst  = cst;
  assign cfg.gain = gain;
  assign ctl.start1  = accept;
  assign ctl.start2  = (state == T_GO2);
  assign ctl.rescale = rescale;
  assign ctl.scale   = scale;

  wpl_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(DIV_N'({bud_mag, {FRAC_BITS{1'b0}}})),
    .den(DIV_D'(total_sat)),
    .done(div_done), .quo(div_quo)
  );

  for (genvar i = 0; i < WHEELS; i++) begin : g_lane
    wpl_lane u_lane (
      .clk(clk), .rst(rst), .ctl(ctl), .cfg(cfg),
      .torque(tq_r[i]), .speed(sp_r[i]),
      .stat(stat[i]), .power(power[i]), .result(res[i])
    );
    assign p1_done_vec[i] = stat[i].p1_done;
    assign p2_done_vec[i] = stat[i].p2_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      cap_lacking <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) cap_lacking <= lack_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      T_IDLE: if (accept) state_next = T_P1;
      T_P1:   if (&p1_done_vec) state_next = T_SUM;
      T_SUM:  if (idx == LANE_IW'(WHEELS - 1)) state_next = T_CMP;
      T_CMP:  state_next = div_start ? T_DIV : T_GO2;
      T_DIV:  if (div_done) state_next = T_GO2;
      T_GO2:  state_next = T_P2;
      T_P2:   if (&p2_done_vec) state_next = T_OUT;
      T_OUT: if (!out_valid || out_ready) begin
        out_load   = 1'b1;
        state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WHEELS; i++) begin
        tq_r[i] <= tq_in[i];
        sp_r[i] <= sp_in[i];
      end
      budget <= budget_next;
    end
    if (state == T_P1) begin
      idx       <= '0;
      total_acc <= '0;
    end
    if (state == T_SUM) begin
      total_acc <= total_acc + TOT_W'(power[idx]);
      idx       <= idx + 1'b1;
    end
    if (state == T_CMP) begin
      limited <= limited_now;
      rescale <= div_start;
    end
    if (div_done) scale <= budget[VAL_W-1] ? -val_t'(div_quo) : val_t'(div_quo);
    if (out_load) begin
      for (int i = 0; i < WHEELS; i++) out_tq[i] <= res[i];
      was_limited <= limited;
      cap_short   <= cap_lacking;
    end
  end

  `WPL_ASSERT_NEXT(a_accept_busy, accept, !in_ready)
  `WPL_ASSERT(a_div_nonzero, div_start |-> (total_sat != '0 && k1 != '0))
  `WPL_ASSERT(a_p2_after_p1, ctl.start2 |-> (&p1_done_vec))
  `WPL_ASSERT(a_out_from_fin, $rose(out_valid) |-> $past(state == T_OUT))
endmodule
`default_nettype wire

FILE: design/wpl_mul.sv
// sequential saturating fixed-point multiplier, one byte of b per cycle
`default_nettype none
module wpl_mul import wpl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t res
);
  localparam int CNT_W = $clog2(MUL_STEPS + 1);
  localparam logic [2*VAL_W-1:0] QMAX_P = (2*VAL_W)'(QMAX);

  logic [VAL_W-1:0]           a_mag;
  logic [MB_W-1:0]            b_sh;
  logic [2*VAL_W-1:0]         acc;
  logic                       neg;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [VAL_W+MUL_CHUNK-1:0] pp;
  logic [2*VAL_W-1:0]         scaled;
  logic [VAL_W-1:0]           mag;

  assign pp     = a_mag * b_sh[MB_W-1 -: MUL_CHUNK];
  assign scaled = acc >> FRAC_BITS;
  assign mag    = (scaled > QMAX_P) ? QMAX_P[VAL_W-1:0] : scaled[VAL_W-1:0];
  assign res    = neg ? -val_t'(mag) : val_t'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MUL_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
      b_sh  <= MB_W'(b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b)) << (MB_W - VAL_W);
      neg   <= a[VAL_W-1] ^ b[VAL_W-1];
      acc   <= '0;
    end else if (busy) begin
      acc  <= (acc << MUL_CHUNK) + (2*VAL_W)'(pp);
      b_sh <= b_sh << MUL_CHUNK;
    end
  end
endmodule
`default_nettype wire

FILE: design/wpl_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module wpl_div import wpl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_N-1:0] num,
  input  logic [DIV_D-1:0] den,
  output logic             done,
  output logic [DIV_N-1:0] quo
);
  localparam int CNT_W = $clog2(DIV_N + 1);

  logic [DIV_D-1:0] rem;
  logic [DIV_D-1:0] den_r;
  logic [DIV_N-1:0] nreg;
  logic [DIV_D:0]   trial;
  logic             fits;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign trial = {rem, nreg[DIV_N-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quo   = nreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      nreg  <= num;
    end else if (busy) begin
      rem  <= fits ? DIV_D'(trial - {1'b0, den_r}) : DIV_D'(trial);
      nreg <= {nreg[DIV_N-2:0], fits};
    end
  end
endmodule
`default_nettype wire

FILE: design/wpl_sqrt.sv
// digit-recurrence integer square root, two radicand bits per cycle
`default_nettype none
module wpl_sqrt import wpl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_IN-1:0]  x,
  output logic              done,
  output logic [SQ_OUT-1:0] root
);
  localparam int CNT_W = $clog2(SQ_OUT + 1);
  localparam int REM_W = SQ_OUT + 2;

  logic [REM_W-1:0]   rem;
  logic [SQ_IN-1:0]   xreg;
  logic [REM_W+1:0]   trial_r;
  logic [REM_W+1:0]   trial_d;
  logic               fits;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  assign trial_r = {rem, xreg[SQ_IN-1 -: 2]};
  assign trial_d = (REM_W+2)'({root, 2'b01});
  assign fits    = trial_r >= trial_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SQ_OUT);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      root <= '0;
      xreg <= x;
    end else if (busy) begin
      rem  <= fits ? REM_W'(trial_r - trial_d) : REM_W'(trial_r);
      root <= {root[SQ_OUT-2:0], fits};
      xreg <= xreg << 2;
    end
  end
endmodule
`default_nettype wire

FILE: design/wpl_lane.sv
// one wheel: power model, then torque re-solve from the scaled power
`default_nettype none
module wpl_lane import wpl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_ctl_t              ctl,
  input  lane_cfg_t              cfg,
  input  logic signed [TQ_W-1:0]  torque,
  input  logic signed [SPD_W-1:0] speed,
  output lane_stat_t             stat,
  output val_t                   power,
  output logic signed [TQ_W-1:0]  result
);
  lane_state_t state, state_next;
  op_t         op, op_next;

  val_t w, acc, tmp, m5;
  val_t t_v, k1_v, k2_v, cst_v;
  val_t mul_a, mul_b, mul_res, d_val, pw_c;
  logic mul_start, mul_done;
  logic sq_start, sq_done, div_start, div_done;
  logic [SQ_OUT-1:0] root;
  logic [DIV_N-1:0]  quo;
  logic signed [SPD_W+K_W:0] wprod;
  logic signed [VAL_W:0]     w_x, root_x, nx;
  logic [VAL_W:0]            num_mag;
  logic                      num_neg;
  logic signed [TQ_W-1:0]    q_sat;

  assign t_v   = val_t'(torque);
  assign k1_v  = val_t'(cfg.k1);
  assign k2_v  = val_t'(cfg.k2);
  assign cst_v = val_t'(cfg.cst);
  assign wprod = speed * $signed({1'b0, cfg.gain});
  assign d_val = clampq(wide_t'(m5) - (wide_t'(tmp) <<< 2));
  assign pw_c  = clampq(wide_t'(acc) + wide_t'(cst_v));

  assign w_x    = (VAL_W+1)'(w);
  assign root_x = (VAL_W+1)'(root);
  // larger root for a forward command, smaller for reverse
  assign nx     = torque[TQ_W-1] ? (-w_x - root_x) : (-w_x + root_x);

  always_comb begin
    if (num_neg) begin
      q_sat = (quo > TQ_NEG_LIM) ? TQ_MIN_S : -$signed(quo[TQ_W-1:0]);
    end else begin
      q_sat = (quo > TQ_POS_LIM) ? TQ_MAX_S : $signed(quo[TQ_W-1:0]);
    end
  end

  always_comb begin
    case (op)
      OP_TW:   begin mul_a = t_v;  mul_b = w;         end
      OP_K1T:  begin mul_a = k1_v; mul_b = t_v;       end
      OP_K1TT: begin mul_a = tmp;  mul_b = t_v;       end
      OP_K2W:  begin mul_a = k2_v; mul_b = w;         end
      OP_K2WW: begin mul_a = tmp;  mul_b = w;         end
      OP_PS:   begin mul_a = acc;  mul_b = ctl.scale; end
      OP_BB:   begin mul_a = w;    mul_b = w;         end
      default: begin mul_a = k1_v; mul_b = tmp;       end
    endcase
  end

  wpl_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  wpl_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start),
    .x(SQ_IN'({d_val[VAL_W-2:0], {FRAC_BITS{1'b0}}})),
    .done(sq_done), .root(root)
  );

  wpl_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(DIV_N'({num_mag, {FRAC_BITS{1'b0}}})),
    .den(DIV_D'({cfg.k1, 1'b0})),
    .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      op    <= OP_TW;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    mul_start  = 1'b0;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      L_IDLE: if (ctl.start1) state_next = L_W;
      L_W: begin
        op_next    = OP_TW;
        state_next = L_GO;
      end
      L_GO: begin
        mul_start  = 1'b1;
        state_next = L_MW;
      end
      L_MW: if (mul_done) begin
        unique case (op)
          OP_TW:   begin op_next = OP_K1T;  state_next = L_GO; end
          OP_K1T:  begin op_next = OP_K1TT; state_next = L_GO; end
          OP_K1TT: begin op_next = OP_K2W;  state_next = L_GO; end
          OP_K2W:  begin op_next = OP_K2WW; state_next = L_GO; end
          OP_K2WW: state_next = L_CST;
          OP_PS:   state_next = L_C1;
          OP_BB:   begin op_next = OP_K1C;  state_next = L_GO; end
          default: state_next = L_D;
        endcase
      end
      L_CST: state_next = L_WAIT;
      L_WAIT: if (ctl.start2) begin
        if (ctl.rescale && acc != '0) begin
          op_next    = OP_PS;
          state_next = L_GO;
        end else begin
          state_next = L_IDLE;
        end
      end
      L_C1: state_next = L_C2;
      L_C2: begin
        op_next    = OP_BB;
        state_next = L_GO;
      end
      L_D: begin
        if (d_val[VAL_W-1]) begin
          state_next = L_IDLE;
        end else begin
          sq_start   = 1'b1;
          state_next = L_SQ;
        end
      end
      L_SQ: if (sq_done) state_next = L_NUM;
      L_NUM: begin
        div_start  = 1'b1;
        state_next = L_DIV;
      end
      L_DIV: if (div_done) state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      L_W: begin
        w      <= clampq(wide_t'(wprod));
        result <= torque;
      end
      L_MW: if (mul_done) begin
        case (op)
          OP_TW:   acc <= mul_res;
          OP_K1TT: acc <= clampq(wide_t'(acc) + wide_t'(mul_res));
          OP_K2WW: begin
            m5  <= mul_res;
            acc <= clampq(wide_t'(acc) + wide_t'(mul_res));
          end
          OP_BB:   m5  <= mul_res;
          default: tmp <= mul_res;
        endcase
      end
      L_CST: acc <= pw_c[VAL_W-1] ? '0 : pw_c;
      L_C1:  tmp <= clampq(wide_t'(m5) - wide_t'(tmp));
      L_C2:  tmp <= clampq(wide_t'(tmp) + wide_t'(cst_v));
      L_SQ: if (sq_done) begin
        num_neg <= nx[VAL_W];
        num_mag <= nx[VAL_W] ? (VAL_W+1)'(-nx) : (VAL_W+1)'(nx);
      end
      L_DIV: if (div_done) result <= q_sat;
      default: ;
    endcase
  end

  assign power        = acc;
  assign stat.p1_done = (state == L_WAIT);
  assign stat.p2_done = (state == L_IDLE);
endmodule
`default_nettype wire

FILE: tb/sv/tb_wheel_power_limiter.sv
// testbench for the wheel power limiter: directed and random ticks against a local predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_wheel_power_limiter;
  import wpl_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 170;
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(28);
  localparam logic signed [63:0] Q_LIM  = (64'sd1 <<< (63 - FRAC_BITS)) - 64'sd1;
  localparam logic signed [63:0] Q_ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] T_HI   = 64'sd8388607;
  localparam logic signed [63:0] T_LO   = -64'sd8388608;

  typedef struct packed {
    logic [WHEELS-1:0][TQ_W-1:0]  tq;
    logic [WHEELS-1:0][SPD_W-1:0] sp;
    logic [ENERGY_W-1:0]          energy;
  } tick_t;

  typedef struct packed {
    logic [WHEELS-1:0][TQ_W-1:0] tq;
    logic                        limited;
    logic                        short_cap;
  } torque_out_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [TQ_W-1:0] torque_0, torque_1, torque_2, torque_3;
  logic signed [SPD_W-1:0] speed_0, speed_1, speed_2, speed_3;
  logic [ENERGY_W-1:0] cap_energy;
  logic signed [TQ_W-1:0] limited_torque_0, limited_torque_1, limited_torque_2, limited_torque_3;
  logic was_limited, cap_short;

  wheel_power_limiter u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .torque_0, .torque_1, .torque_2, .torque_3,
    .speed_0, .speed_1, .speed_2, .speed_3, .cap_energy,
    .out_valid, .out_ready, .limited_torque_0, .limited_torque_1,
    .limited_torque_2, .limited_torque_3, .was_limited, .cap_short
  );

  // shadow of the register file and the capacitor flag
  logic [K_W-1:0]     sh_k1, sh_k2, sh_cst, sh_gain;
  logic [LIM_W-1:0]   sh_limit;
  logic [BOOST_W-1:0] sh_boost;
  logic               sh_cap_en;
  logic               lacking;

  torque_out_t torque_q[$];
  int errors, ticks_sent, ticks_seen, ticks_limited, idle_cycles;
  int send_idle_pct, recv_stall_pct;

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > Q_LIM) return Q_LIM;
    if (v < -Q_LIM) return -Q_LIM;
    return v;
  endfunction

  // magnitude product, truncated and saturated, then signed
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [63:0]  ua, ub, p;
    logic [127:0] pr;
    logic         neg;
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    neg = (a < 0) != (b < 0);
    pr  = {64'd0, ua} * {64'd0, ub};
    if (pr > 128'h7FFF_FFFF_FFFF_FFFF) begin
      p = 64'(Q_LIM);
    end else begin
      p = 64'(pr >> FRAC_BITS);
      if (p > 64'(Q_LIM)) p = 64'(Q_LIM);
    end
    return neg ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic torque_out_t limit_torques(input tick_t it);
    torque_out_t o;
    logic signed [63:0] t[WHEELS], w[WHEELS], p[WHEELS], r[WHEELS];
    logic signed [63:0] total, budget, k1, k2, cst, s, pw, scale, sp, b, c, d, root, num, q;
    logic lim;
    k1  = {40'd0, sh_k1};
    k2  = {40'd0, sh_k2};
    cst = {40'd0, sh_cst};
    if (it.energy > ENERGY_SET) begin
      if (it.energy > ENERGY_CLR) lacking = 1'b0;
    end else begin
      lacking = 1'b1;
    end
    budget = {54'd0, sh_limit} * Q_ONE;
    if (sh_limit <= LIM_THRESH) budget = budget - LIM_MARGIN * Q_ONE;
    if (sh_cap_en && !lacking) budget = budget + {38'd0, sh_boost};
    total = 64'sd0;
    for (int i = 0; i < WHEELS; i++) begin
      s    = 64'($signed(it.sp[i]));
      t[i] = 64'($signed(it.tq[i]));
      r[i] = t[i];
      w[i] = sat(s * $signed({40'd0, sh_gain}));
      pw   = sat(qmul(t[i], w[i]) + qmul(qmul(k1, t[i]), t[i]));
      pw   = sat(pw + qmul(qmul(k2, w[i]), w[i]));
      pw   = sat(pw + cst);
      if (pw < 0) pw = 64'sd0;
      p[i]  = pw;
      total = sat(total + pw);
    end
    lim = total > budget;
    if (lim && total > 0 && k1 != 0) begin
      scale = sat((budget * Q_ONE) / total);
      for (int i = 0; i < WHEELS; i++) begin
        if (p[i] != 0) begin
          sp = qmul(p[i], scale);
          b  = w[i];
          c  = sat(sat(qmul(qmul(k2, b), b) - sp) + cst);
          d  = sat(qmul(b, b) - 4 * qmul(k1, c));
          // negative discriminant keeps the command
          if (d >= 0) begin
            root = $signed(int_sqrt(64'(d) << FRAC_BITS));
            num  = sat((t[i] >= 0) ? -b + root : -b - root);
            q    = (num * Q_ONE) / (2 * k1);
            if (q > T_HI) q = T_HI;
            if (q < T_LO) q = T_LO;
            r[i] = q;
          end
        end
      end
    end
    for (int i = 0; i < WHEELS; i++) o.tq[i] = r[i][TQ_W-1:0];
    o.limited   = lim;
    o.short_cap = lacking;
    return o;
  endfunction

  function automatic tick_t mk(input int t0, input int t1, input int t2, input int t3,
                               input int s0, input int s1, input int s2, input int s3,
                               input int en);
    tick_t it;
    it.tq[0] = TQ_W'(t0); it.tq[1] = TQ_W'(t1); it.tq[2] = TQ_W'(t2); it.tq[3] = TQ_W'(t3);
    it.sp[0] = SPD_W'(s0); it.sp[1] = SPD_W'(s1); it.sp[2] = SPD_W'(s2); it.sp[3] = SPD_W'(s3);
    it.energy = ENERGY_W'(en);
    return it;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    torque_out_t ex;
    logic [WHEELS-1:0][TQ_W-1:0] got;
    if (rst) begin
      out_ready   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_valid && out_ready) begin
        ticks_seen++;
        if (torque_q.size() == 0) begin
          $error("result beat with no tick pending");
          errors++;
        end else begin
          ex  = torque_q.pop_front();
          got = {limited_torque_3, limited_torque_2, limited_torque_1, limited_torque_0};
          for (int i = 0; i < WHEELS; i++) begin
            if (got[i] !== ex.tq[i]) begin
              $error("limited_torque_%0d expected %0d got %0d", i,
                     $signed(ex.tq[i]), $signed(got[i]));
              errors++;
            end
          end
          if (was_limited !== ex.limited) begin
            $error("was_limited expected %0d got %0d", ex.limited, was_limited);
            errors++;
          end
          if (cap_short !== ex.short_cap) begin
            $error("cap_short expected %0d got %0d", ex.short_cap, cap_short);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_tick(input tick_t it);
    torque_out_t ex;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    torque_0 <= it.tq[0]; torque_1 <= it.tq[1]; torque_2 <= it.tq[2]; torque_3 <= it.tq[3];
    speed_0 <= it.sp[0]; speed_1 <= it.sp[1]; speed_2 <= it.sp[2]; speed_3 <= it.sp[3];
    cap_energy <= it.energy;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    ex = limit_torques(it);
    if (ex.limited) ticks_limited++;
    torque_q.push_back(ex);
    ticks_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (torque_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic [ADDR_W-1:0] addr, input logic wr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rd, want;
    drain();
    apb_access(ADDR_W'(4 * int'(idx)), 1'b1, val, rd);
    case (idx)
      REG_K1:     sh_k1     = val[K_W-1:0];
      REG_K2:     sh_k2     = val[K_W-1:0];
      REG_CST:    sh_cst    = val[K_W-1:0];
      REG_LIMIT:  sh_limit  = val[LIM_W-1:0];
      REG_BOOST:  sh_boost  = val[BOOST_W-1:0];
      REG_CAP_EN: sh_cap_en = val[0];
      REG_GAIN:   sh_gain   = val[K_W-1:0];
      default: ;
    endcase
    case (idx)
      REG_K1:     want = DATA_W'(sh_k1);
      REG_K2:     want = DATA_W'(sh_k2);
      REG_CST:    want = DATA_W'(sh_cst);
      REG_LIMIT:  want = DATA_W'(sh_limit);
      REG_BOOST:  want = DATA_W'(sh_boost);
      REG_CAP_EN: want = DATA_W'(sh_cap_en);
      default:    want = DATA_W'(sh_gain);
    endcase
    @(posedge clk);
    apb_access(ADDR_W'(4 * int'(idx)), 1'b0, '0, rd);
    if (rd !== want) begin
      $error("prdata reg %s expected %0h got %0h", idx.name(), want, rd);
      errors++;
    end
  endtask

  task automatic set_all(input int k1, input int k2, input int cst, input int lim,
                         input int boost, input int en, input int gain);
    set_reg(REG_K1, k1);
    set_reg(REG_K2, k2);
    set_reg(REG_CST, cst);
    set_reg(REG_LIMIT, lim);
    set_reg(REG_BOOST, boost);
    set_reg(REG_CAP_EN, en);
    set_reg(REG_GAIN, gain);
  endtask

  task automatic test_reset_defaults;
    send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(8388607, 8388607, 8388607, 8388607, 32767, 32767, 32767, 32767, 65535));
    send_tick(mk(-8388608, -8388608, -8388608, -8388608, -32768, -32768, -32768, -32768, 3));
    send_tick(mk(8388607, -8388608, 65536, -65536, -32768, 32767, 100, -100, 12));
    send_tick(mk(65536, 0, -131072, 30000, 20, 0, -15, 5, 8));
    drain();
  endtask

  task automatic test_cap_hysteresis;
    int levels[10] = '{11, 8, 6, 8, 10, 11, 65535, 7, 0, 9};
    set_all(65536, 0, 0, 50, 20 * 65536, 1, 65536);
    foreach (levels[i]) send_tick(mk(65536, 65536, -65536, 32768, 50, 40, -30, 20, levels[i]));
    drain();
  endtask

  task automatic test_budget_edges;
    // negative budget, then zero total over a negative budget
    set_all(65536, 0, 0, 1, 0, 0, 65536);
    send_tick(mk(65536, 65536, 0, -65536, 10, -10, 0, 10, 20));
    send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 20));
    set_reg(REG_LIMIT, 90);
    send_tick(mk(200000, 300000, 0, -400000, 80, 60, 0, -70, 20));
    set_reg(REG_LIMIT, 91);
    send_tick(mk(200000, 300000, 0, -400000, 80, 60, 0, -70, 20));
    set_reg(REG_LIMIT, 1023);
    send_tick(mk(8388607, 8388607, -8388608, 8388607, 32767, 1000, -1000, 500, 20));
    // no quadratic without copper loss
    set_reg(REG_K1, 0);
    send_tick(mk(3000000, -3000000, 1000000, 1, 900, -900, 300, 1, 20));
    // large static power drives the discriminant negative on the wheel at standstill
    set_all(1, 1000, 16777215, 5, 0, 0, 65536);
    send_tick(mk(65536, -65536, 0, 131072, 30, 30, 0, -30, 20));
    // saturation of speed and powers
    set_all(16777215, 16777215, 16777215, 1023, 67108863, 1, 16777215);
    send_tick(mk(8388607, -8388608, 1, -1, 32767, -32768, 32767, -32768, 65535));
    set_reg(REG_GAIN, 0);
    send_tick(mk(8388607, -8388608, 1, -1, 32767, -32768, 32767, -32768, 65535));
    // write past the register list is dropped
    drain();
    begin
      logic [DATA_W-1:0] rd;
      apb_access(UNUSED_ADDR, 1'b1, 32'hFFFF_FFFF, rd);
    end
    send_tick(mk(100000, 0, 0, 0, 10, 0, 0, 0, 20));
    drain();
  endtask

  task automatic rand_config(input bit extreme);
    if (extreme) begin
      set_all($urandom_range(1) ? 1 : 16777215, $urandom_range(1) ? 0 : 16777215,
              $urandom_range(1) ? 0 : 16777215, $urandom_range(1) ? 1 : 1023,
              $urandom_range(1) ? 0 : 67108863, $urandom_range(1),
              $urandom_range(1) ? 0 : 16777215);
    end else begin
      set_all($urandom_range(200000, 500), $urandom_range(2000), $urandom_range(200000),
              $urandom_range(200, 1), $urandom_range(3000000), $urandom_range(1),
              $urandom_range(20000, 1000));
    end
  endtask

  function automatic tick_t rand_tick;
    tick_t it;
    if ($urandom_range(99) < 70) begin
      for (int i = 0; i < WHEELS; i++) begin
        it.tq[i] = TQ_W'($signed($urandom_range(1600000)) - 800000);
        it.sp[i] = SPD_W'($signed($urandom_range(1600)) - 800);
      end
      it.energy = ($urandom_range(9) == 0) ? ENERGY_W'($urandom) : ENERGY_W'($urandom_range(16));
    end else begin
      for (int i = 0; i < WHEELS; i++) begin
        it.tq[i] = TQ_W'($urandom);
        it.sp[i] = SPD_W'($urandom);
      end
      it.energy = ENERGY_W'($urandom);
    end
    return it;
  endfunction

  task automatic test_random;
    int idle_tab[4]  = '{0, 54, 0, 36};
    int stall_tab[4] = '{0, 0, 54, 36};
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      send_idle_pct  = idle_tab[ph % 4];
      recv_stall_pct = stall_tab[ph % 4];
      rand_config(ph == 1 || ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        send_tick(rand_tick());
      end
      drain();
    end
  endtask

  initial begin
    errors = 0; ticks_sent = 0; ticks_seen = 0; ticks_limited = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    torque_0 = '0; torque_1 = '0; torque_2 = '0; torque_3 = '0;
    speed_0 = '0; speed_1 = '0; speed_2 = '0; speed_3 = '0; cap_energy = '0;
    sh_k1 = K1_RESET; sh_k2 = '0; sh_cst = '0; sh_gain = GAIN_RESET;
    sh_limit = LIMIT_RESET; sh_boost = '0; sh_cap_en = 1'b0; lacking = 1'b1;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    send_idle_pct = 36; recv_stall_pct = 36;
    test_cap_hysteresis();
    test_budget_edges();
    test_random();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d ticks, %0d results, %0d over budget", ticks_sent, ticks_seen,
             ticks_limited);
    $display("register extremes, capacitor hysteresis and four idling mixes exercised");
    if (errors == 0 && torque_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+design
design/wpl_pkg.sv
design/wpl_mul.sv
design/wpl_div.sv
design/wpl_sqrt.sv
design/wpl_lane.sv
design/wheel_power_limiter.sv
tb/sv/tb_wheel_power_limiter.sv
